// File: src/m2g4_pkg.sv
`timescale 1ns / 1ps

package m2g4_pkg;

  // Frame geometry
  localparam int PIXEL_COLUMNS = 256;
  localparam int PIXEL_ROWS    = 64;

  localparam int ROW_BYTES     = PIXEL_COLUMNS / 2;
  localparam int PAGE_COUNT    = (PIXEL_ROWS / 8 == 0) ? 1 : PIXEL_ROWS / 8;
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W         = $clog2(ROW_BYTES);
  localparam int COL_STEP      = 2;

  // Rows of one page and tiles of one beat
  localparam int ROWS_PER_PAGE = 8;
  localparam int ROW_W         = $clog2(ROWS_PER_PAGE);
  localparam int TILES         = 4;
  localparam int TILE_W        = 8;
  localparam int PAIR_W        = 8;
  localparam int ADDR_W        = 13;

  // Address arithmetic width, never narrower than the address port
  localparam int CALC_RAW      = PAGE_W + ROW_W + COL_W + 1;
  localparam int CALC_W        = (CALC_RAW > ADDR_W) ? CALC_RAW : ADDR_W;

  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS_PER_PAGE - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE     = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [COL_W:0]    ROW_BYTES_CMP = (COL_W + 1)'(ROW_BYTES);

  // Grey levels of a set pixel in either nibble
  localparam logic [PAIR_W-1:0] NIBBLE_HI = 8'hF0;
  localparam logic [PAIR_W-1:0] NIBBLE_LO = 8'h0F;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [TILES-1:0][TILE_W-1:0] tiles;
    logic [PAGE_W-1:0]            page;
    logic [COL_W-1:0]             col;
    logic                         last_item;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic [PAIR_W-1:0] first_pixel_pair;
    logic [PAIR_W-1:0] second_pixel_pair;
    logic              last_of_run;
    logic              frame_done;
  } result_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              valid;
  } queue_status_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             out_valid;
  } back_status_t;

endpackage

// File: src/m2g4_front.sv
`timescale 1ns / 1ps

module m2g4_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [m2g4_pkg::TILE_W-1:0]        tile_byte_0,
  input  logic [m2g4_pkg::TILE_W-1:0]        tile_byte_1,
  input  logic [m2g4_pkg::TILE_W-1:0]        tile_byte_2,
  input  logic [m2g4_pkg::TILE_W-1:0]        tile_byte_3,
  output m2g4_pkg::entry_t                   entry
);

  logic [m2g4_pkg::PAGE_W-1:0] page;
  logic [m2g4_pkg::COL_W-1:0]  col;
  logic [m2g4_pkg::COL_W:0]    next_col;
  logic                        col_wraps;
  logic                        last_item;

  // Classify the beat against the current position
  assign next_col  = {1'b0, col} + (m2g4_pkg::COL_W + 1)'(m2g4_pkg::COL_STEP);
  assign col_wraps = (next_col >= m2g4_pkg::ROW_BYTES_CMP);
  assign last_item = col_wraps && (page == m2g4_pkg::LAST_PAGE);

  always_comb begin
    entry.tiles[0]  = tile_byte_0;
    entry.tiles[1]  = tile_byte_1;
    entry.tiles[2]  = tile_byte_2;
    entry.tiles[3]  = tile_byte_3;
    entry.page      = page;
    entry.col       = col;
    entry.last_item = last_item;
  end

  // Advance the column, wrap to the next page and to frame start
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
      col  <= '0;
    end else if (accept) begin
      if (last_item) begin
        page <= '0;
        col  <= '0;
      end else if (col_wraps) begin
        page <= page + 1'b1;
        col  <= '0;
      end else begin
        col  <= next_col[m2g4_pkg::COL_W-1:0];
      end
    end
  end

endmodule

// File: src/m2g4_queue.sv
`timescale 1ns / 1ps

module m2g4_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  m2g4_pkg::entry_t        wr_data,
  input  logic                    rd_en,
  output m2g4_pkg::entry_t        rd_data,
  output m2g4_pkg::queue_status_t status
);

  m2g4_pkg::entry_t              slots [m2g4_pkg::QDEPTH];
  logic [m2g4_pkg::QPTR_W-1:0]   wr_ptr;
  logic [m2g4_pkg::QPTR_W-1:0]   rd_ptr;
  logic [m2g4_pkg::QCNT_W-1:0]   count;

  localparam logic [m2g4_pkg::QPTR_W-1:0] PTR_LAST = m2g4_pkg::QPTR_W'(m2g4_pkg::QDEPTH - 1);
  localparam logic [m2g4_pkg::QCNT_W-1:0] CNT_FULL = m2g4_pkg::QCNT_W'(m2g4_pkg::QDEPTH);

  // Present the oldest entry and the fill state
  assign rd_data      = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == CNT_FULL);
  assign status.valid = (count != '0);

  // Store a beat at the write pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/m2g4_back.sv
`timescale 1ns / 1ps

module m2g4_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  m2g4_pkg::entry_t       head,
  output logic                   head_pop,
  input  logic                   res_pop,
  output m2g4_pkg::result_t      res,
  output m2g4_pkg::back_status_t status
);

  logic [m2g4_pkg::ROW_W-1:0]                  row;
  logic                                        out_valid;
  logic                                        load;
  logic [m2g4_pkg::PAGE_W+m2g4_pkg::ROW_W-1:0] pixel_row;
  logic [m2g4_pkg::CALC_W-1:0]                 addr_calc;
  logic [m2g4_pkg::PAIR_W-1:0]                 first_pair;
  logic [m2g4_pkg::PAIR_W-1:0]                 second_pair;

  // Take a row from a valid head whenever the output register is free or being drained
  assign load     = head_valid && (!out_valid || res_pop);
  assign head_pop = load && (row == m2g4_pkg::LAST_ROW);

  assign status.row       = row;
  assign status.out_valid = out_valid;

  // Form the frame address of this pixel row
  assign pixel_row = {head.page, row};
  assign addr_calc = m2g4_pkg::CALC_W'(pixel_row) * m2g4_pkg::CALC_W'(m2g4_pkg::ROW_BYTES)
                   + m2g4_pkg::CALC_W'(head.col);

  // Expand one pixel of each column into a grey nibble
  assign first_pair  = (head.tiles[0][row] ? m2g4_pkg::NIBBLE_HI : '0)
                     | (head.tiles[1][row] ? m2g4_pkg::NIBBLE_LO : '0);
  assign second_pair = (head.tiles[2][row] ? m2g4_pkg::NIBBLE_HI : '0)
                     | (head.tiles[3][row] ? m2g4_pkg::NIBBLE_LO : '0);

  // Hold the result until it is popped
  always_ff @(posedge clk) begin
    if (load) begin
      res.frame_address     <= addr_calc[m2g4_pkg::ADDR_W-1:0];
      res.first_pixel_pair  <= first_pair;
      res.second_pixel_pair <= second_pair;
      res.last_of_run       <= (row == m2g4_pkg::LAST_ROW);
      res.frame_done        <= (row == m2g4_pkg::LAST_ROW) && head.last_item;
    end
  end

  // Step the row counter and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        row       <= row + 1'b1;
        out_valid <= 1'b1;
      end else if (res_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/mono_page_to_gray4_converter.sv
`timescale 1ns / 1ps
// An accepted beat is written into the queue; its first row result is then registered in the back-end output register.
// One row result per cycle while the queue holds a beat and results are popped, from the back-end row counter.
// A two-entry queue lets the front take new beats while the back still emits rows.
// Reset (synchronous, rst high) clears page/column position, queue and output valid.

module mono_page_to_gray4_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [m2g4_pkg::TILE_W-1:0]       tile_byte_0,
  input  logic [m2g4_pkg::TILE_W-1:0]       tile_byte_1,
  input  logic [m2g4_pkg::TILE_W-1:0]       tile_byte_2,
  input  logic [m2g4_pkg::TILE_W-1:0]       tile_byte_3,
  output logic                              empty,
  input  logic                              pop,
  output logic [m2g4_pkg::ADDR_W-1:0]       frame_address,
  output logic [m2g4_pkg::PAIR_W-1:0]       first_pixel_pair,
  output logic [m2g4_pkg::PAIR_W-1:0]       second_pixel_pair,
  output logic                              last_of_run,
  output logic                              frame_done
);

  logic                      accept;
  logic                      head_pop;
  logic                      res_pop;
  m2g4_pkg::entry_t          entry;
  m2g4_pkg::entry_t          head;
  m2g4_pkg::queue_status_t   qstat;
  m2g4_pkg::result_t         res;
  m2g4_pkg::back_status_t    bstat;

  // Handshake on both sides
  assign accept  = push && !qstat.full;
  assign full    = qstat.full;
  assign empty   = !bstat.out_valid;
  assign res_pop = pop && bstat.out_valid;

  m2g4_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .tile_byte_0 (tile_byte_0),
    .tile_byte_1 (tile_byte_1),
    .tile_byte_2 (tile_byte_2),
    .tile_byte_3 (tile_byte_3),
    .entry       (entry)
  );

  m2g4_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (entry),
    .rd_en   (head_pop),
    .rd_data (head),
    .status  (qstat)
  );

  m2g4_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (qstat.valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_pop    (res_pop),
    .res        (res),
    .status     (bstat)
  );

  // Drive the result ports
  assign frame_address     = res.frame_address;
  assign first_pixel_pair  = res.first_pixel_pair;
  assign second_pixel_pair = res.second_pixel_pair;
  assign last_of_run       = res.last_of_run;
  assign frame_done        = res.frame_done;

`ifndef SYNTHESIS
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> last_of_run)
    else $error("frame_done without last_of_run");

  a_run_end_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_run) |-> (bstat.row == '0))
    else $error("row counter not wrapped after last row of a beat");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= m2g4_pkg::QCNT_W'(m2g4_pkg::QDEPTH))
    else $error("queue fill count out of range");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> qstat.valid)
    else $error("back end popped an empty queue");
`endif

endmodule
